[rtl/core/tgarle_pkg.sv]
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants for the Targa RLE true-color pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tgarle_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DimW     = 16;
  localparam int unsigned PixW     = 32;
  localparam int unsigned CountW   = 8;
  localparam int unsigned TotalW   = 2 * DimW;

  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;
  typedef logic [PixW-1:0]     argb_t;
  typedef logic [CountW-1:0]   count_t;
  typedef logic [TotalW-1:0]   total_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_DEPTH_IS_32  = 2'd2;
  localparam cfg_idx_t CFG_RLE_MODE     = 2'd3;

  localparam logic [7:0] RUN_FLAG_MASK = 8'h80;
  localparam logic [7:0] COUNT_MASK    = 8'h7F;
  localparam logic [7:0] OPAQUE_ALPHA  = 8'hFF;

  localparam logic [1:0] BYTE_RED   = 2'd2;
  localparam logic [1:0] BYTE_ALPHA = 2'd3;

endpackage : tgarle_pkg

`default_nettype wire

[rtl/core/tga_rle_pixel_decoder_top.sv]
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// Decodes TGA true-color pixel data (raw or run-length packed) into ARGB.
// ----------------------------------------------------------------------------
// The block takes one pixel-data byte per transaction: the whole state update
// (packet header decode, byte gather, run count, clip against the image size)
// sits between the state registers and a single output register, so a byte is
// accepted every cycle while the output slot is empty or being drained and no
// size recompute is pending. A finished pixel appears in the cycle after its
// last byte as ARGB (alpha forced to 0xFF for 24-bit data), with the number of
// identical consecutive pixels it stands for, clipped to the pixels still
// missing from the image, and image_done set on the pixel that completes the
// image. Header bytes and partial pixels produce no output transaction. After
// completion all bytes are dropped until a byte arrives with image_start set,
// which clears progress before that byte is decoded. Image size is held as a
// registered width*height product; each configuration write stalls the input
// while the product is recomputed. Configuration is expected only while the
// decoder is idle; writes to the port take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder_top (
  input  wire                   clk,
  input  wire                   rst_n,
  // configuration
  input  wire                   cfg_we,
  input  tgarle_pkg::cfg_idx_t  cfg_index,
  input  tgarle_pkg::cfg_data_t cfg_data,
  // input byte stream
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire [7:0]             in_data_byte,
  input  wire                   in_image_start,
  // decoded pixels
  output logic                  out_valid,
  input  wire                   out_ready,
  output tgarle_pkg::argb_t     out_pixel_argb,
  output tgarle_pkg::count_t    out_repeat_count,
  output logic                  out_image_done
);

  import tgarle_pkg::*;

  // configuration registers
  logic [DimW-1:0] width_r;
  logic [DimW-1:0] height_r;
  logic            depth32_r;
  logic            rle_r;
  // cached image size, stale after any write until recomputed
  total_t          total_r;
  logic            total_stale_r;

  // decode state
  logic       expect_hdr_r, expect_hdr_nxt;
  logic       is_run_r, is_run_nxt;
  count_t     left_r, left_nxt;
  logic [1:0] bip_r, bip_nxt;
  argb_t      gather_r, gather_nxt;
  total_t     done_r, done_nxt;
  logic       complete_r, complete_nxt;

  // output slot
  logic   out_valid_r, out_valid_nxt;
  argb_t  out_argb_r, out_argb_nxt;
  count_t out_count_r, out_count_nxt;
  logic   out_done_r, out_done_nxt;

  logic in_fire;

  // progress after an optional image_start clear
  logic       eff_expect, eff_run, eff_complete;
  count_t     eff_left;
  logic [1:0] eff_bip;
  argb_t      eff_gather;
  total_t     eff_done;

  argb_t  gathered, argb;
  logic   finished;
  count_t count, count_clip;
  total_t remaining, done_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r       <= DimW'(1);
      height_r      <= DimW'(1);
      depth32_r     <= 1'b0;
      rle_r         <= 1'b1;
      total_r       <= TotalW'(1);
      total_stale_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IMAGE_WIDTH:  width_r   <= cfg_data[DimW-1:0];
          CFG_IMAGE_HEIGHT: height_r  <= cfg_data[DimW-1:0];
          CFG_DEPTH_IS_32:  depth32_r <= cfg_data[0];
          CFG_RLE_MODE:     rle_r     <= cfg_data[0];
          default: ;
        endcase
      end
      if (total_stale_r) begin
        total_r <= TotalW'(width_r) * TotalW'(height_r);
      end
      total_stale_r <= cfg_we;
    end
  end

  assign in_ready = !total_stale_r && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    eff_expect   = in_image_start ? 1'b1          : expect_hdr_r;
    eff_run      = in_image_start ? 1'b0          : is_run_r;
    eff_left     = in_image_start ? '0            : left_r;
    eff_bip      = in_image_start ? 2'd0          : bip_r;
    eff_gather   = in_image_start ? '0            : gather_r;
    eff_done     = in_image_start ? '0            : done_r;
    eff_complete = in_image_start ? 1'b0          : complete_r;

    // replace the selected byte lane with the new byte
    gathered = eff_gather;
    case (eff_bip)
      2'd0:    gathered[7:0]   = in_data_byte;
      2'd1:    gathered[15:8]  = in_data_byte;
      2'd2:    gathered[23:16] = in_data_byte;
      default: gathered[31:24] = in_data_byte;
    endcase
    finished = (eff_bip == BYTE_ALPHA) || (eff_bip == BYTE_RED && !depth32_r);
    argb     = depth32_r ? gathered : {OPAQUE_ALPHA, gathered[23:0]};

    // run length; an empty packet counts as one pixel
    if (rle_r && eff_run) begin
      count = (eff_left == '0) ? CountW'(1) : eff_left;
    end else begin
      count = CountW'(1);
    end

    remaining  = (eff_done < total_r) ? total_r - eff_done : '0;
    count_clip = (remaining < TotalW'(count)) ? remaining[CountW-1:0] : count;
    done_sum   = eff_done + TotalW'(count_clip);

    expect_hdr_nxt = expect_hdr_r;
    is_run_nxt     = is_run_r;
    left_nxt       = left_r;
    bip_nxt        = bip_r;
    gather_nxt     = gather_r;
    done_nxt       = done_r;
    complete_nxt   = complete_r;

    out_valid_nxt = out_valid_r && !out_ready;
    out_argb_nxt  = out_argb_r;
    out_count_nxt = out_count_r;
    out_done_nxt  = out_done_r;

    if (in_fire) begin
      expect_hdr_nxt = eff_expect;
      is_run_nxt     = eff_run;
      left_nxt       = eff_left;
      bip_nxt        = eff_bip;
      gather_nxt     = eff_gather;
      done_nxt       = eff_done;
      complete_nxt   = eff_complete;

      if (!eff_complete) begin
        if (rle_r && eff_expect) begin
          // packet header
          is_run_nxt     = (in_data_byte & RUN_FLAG_MASK) != 8'h00;
          left_nxt       = (in_data_byte & COUNT_MASK) + CountW'(1);
          expect_hdr_nxt = 1'b0;
        end else begin
          gather_nxt = gathered;
          if (!finished) begin
            bip_nxt = eff_bip + 2'd1;
          end else begin
            bip_nxt = 2'd0;
            if (rle_r) begin
              if (eff_run || eff_left <= CountW'(1)) begin
                left_nxt       = '0;
                expect_hdr_nxt = 1'b1;
              end else begin
                left_nxt = eff_left - CountW'(1);
              end
            end
            if (remaining == '0) begin
              // size shrunk below progress: close the image silently
              complete_nxt = 1'b1;
            end else begin
              done_nxt      = done_sum;
              complete_nxt  = (done_sum == total_r);
              out_valid_nxt = 1'b1;
              out_argb_nxt  = argb;
              out_count_nxt = count_clip;
              out_done_nxt  = (done_sum == total_r);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_hdr_r <= 1'b1;
      is_run_r     <= 1'b0;
      left_r       <= '0;
      bip_r        <= 2'd0;
      gather_r     <= '0;
      done_r       <= '0;
      complete_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      expect_hdr_r <= expect_hdr_nxt;
      is_run_r     <= is_run_nxt;
      left_r       <= left_nxt;
      bip_r        <= bip_nxt;
      gather_r     <= gather_nxt;
      done_r       <= done_nxt;
      complete_r   <= complete_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_argb_r  <= out_argb_nxt;
    out_count_r <= out_count_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_argb   = out_argb_r;
  assign out_repeat_count = out_count_r;
  assign out_image_done   = out_done_r;

  // a configuration write blocks input until the size product is refreshed
  a_cfg_stalls_input : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input accepted while image size was being recomputed");

  // every pixel stands for between 1 and 128 pixels
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r != '0) && (out_count_r <= CountW'(128)))
    else $error("repeat count out of range");

  // once complete, bytes without image_start leave progress untouched
  a_complete_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (complete_r && in_fire && !in_image_start) |=> $stable(done_r) && complete_r)
    else $error("progress changed after image completion");

endmodule : tga_rle_pixel_decoder_top

`default_nettype wire
